[rtl/tccw_pkg.sv]
package tccw_pkg;

  // Grid size defaults
  localparam int unsigned TCCW_COLS = 80;
  localparam int unsigned TCCW_ROWS = 25;

  // Command codes
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  // Colors
  localparam logic [31:0] WHITE_ALL = 32'hffffffff;
  localparam logic [31:0] WHITE_RGB = 32'h00ffffff;

  // Character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_THREE    = 8'h33;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_M        = 8'h6d;

  // One command beat
  typedef struct packed {
    logic        command;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [7:0]  glyph;
    logic [31:0] draw_color;
    logic        last_of_run;
  } res_t;

  // Color selected by an escape digit 1..9
  function automatic logic [31:0] digit_color(input logic [3:0] digit);
    logic [31:0] color;
    case (digit)
      4'd1:    color = 32'h00ff0000;
      4'd2:    color = 32'h0000ff00;
      4'd3:    color = 32'h00ffff00;
      4'd4:    color = 32'h000000ff;
      4'd5:    color = 32'h00aa00ff;
      4'd6:    color = 32'h0000aaff;
      default: color = WHITE_RGB;
    endcase
    return color;
  endfunction

endpackage

[rtl/tccw_char_if.sv]
interface tccw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

[rtl/tccw_cmd_if.sv]
interface tccw_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;
  logic [7:0]  glyph;
  logic [31:0] draw_color;
  logic        last_of_run;

  modport source (
    output valid, output command, output cell_column, output cell_row,
    output glyph, output draw_color, output last_of_run, input ready
  );
  modport sink (
    input valid, input command, input cell_column, input cell_row,
    input glyph, input draw_color, input last_of_run, output ready
  );
endinterface

[rtl/text_console_char_writer.sv]
// An accepted character sits in the input register, its commands then in the queue.
// Throughput: one character per cycle when it makes at most one command and the queue has
// room; one that makes two (newline at the bottom row, wrap with scroll) waits until both
// fit the 2-entry queue; the single command port drains one beat per cycle while ready.
// Reset: caret at column 0 row 0, escape parser idle, color all ones, limit 0, queue empty.
module text_console_char_writer import tccw_pkg::*; #(
  parameter int unsigned COLS = TCCW_COLS,
  parameter int unsigned ROWS = TCCW_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tccw_char_if.sink  char_i,
  tccw_cmd_if.source cmd_o
);

  localparam logic [7:0] ColsW   = 8'(COLS);
  localparam logic [7:0] LastRow = 8'(ROWS - 1);

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_ONE,
    ESC_SEMI,
    ESC_THREE,
    ESC_ZERO,
    ESC_DIGIT
  } esc_e;

  esc_e        esc_q, esc_d;
  logic [3:0]  digit_q, digit_d;
  logic [31:0] color_q, color_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic [7:0]  limit_q;
  logic [7:0]  in_q;
  logic        in_vld_q;

  logic        consumed;
  logic [1:0]  n_res;
  res_t [1:0]  res;
  logic [1:0]  free;
  logic        fire;
  logic [7:0]  ch;

  function automatic res_t make_res(input logic cmd, input logic [7:0] c,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [31:0] color);
    res_t x;
    x.command     = cmd;
    x.cell_column = c;
    x.cell_row    = r;
    x.glyph       = g;
    x.draw_color  = color;
    x.last_of_run = 1'b0;
    return x;
  endfunction

  localparam res_t ScrollRes = '{
    command: CMD_SCROLL, cell_column: 8'd0, cell_row: LastRow,
    glyph: CH_SPACE, draw_color: WHITE_ALL, last_of_run: 1'b0
  };

  assign ch           = in_q;
  assign fire         = in_vld_q && (n_res <= free);
  assign char_i.ready = !in_vld_q || fire;

  // Escape parser, caret moves and command build for the held character
  always_comb begin
    esc_d    = esc_q;
    digit_d  = digit_q;
    color_d  = color_q;
    col_d    = col_q;
    row_d    = row_q;
    consumed = 1'b0;
    n_res    = 2'd0;
    res[0]   = ScrollRes;
    res[1]   = ScrollRes;

    if (ch >= CH_ONE && ch <= CH_NINE && esc_q == ESC_THREE) begin
      esc_d    = ESC_DIGIT;
      digit_d  = ch[3:0];
      consumed = 1'b1;
    end else if (ch == CH_M && esc_q == ESC_DIGIT) begin
      color_d  = digit_color(digit_q);
      esc_d    = ESC_IDLE;
      consumed = 1'b1;
    end else begin
      case (ch)
        CH_ESC: begin
          esc_d    = ESC_SEEN;
          consumed = 1'b1;
        end
        CH_LBRACKET: begin
          if (esc_q == ESC_SEEN) begin
            esc_d    = ESC_BRACKET;
            consumed = 1'b1;
          end
        end
        CH_ONE: begin
          if (esc_q == ESC_BRACKET) begin
            esc_d    = ESC_ONE;
            consumed = 1'b1;
          end
        end
        CH_SEMI: begin
          if (esc_q == ESC_ONE) begin
            esc_d    = ESC_SEMI;
            consumed = 1'b1;
          end
        end
        CH_THREE: begin
          if (esc_q == ESC_SEMI) begin
            esc_d    = ESC_THREE;
            consumed = 1'b1;
          end
        end
        CH_ZERO: begin
          if (esc_q == ESC_BRACKET) begin
            esc_d    = ESC_ZERO;
            consumed = 1'b1;
          end
        end
        CH_M: begin
          if (esc_q == ESC_ZERO) begin
            color_d  = WHITE_ALL;
            consumed = 1'b1;
          end
          esc_d = ESC_IDLE;
        end
        default: esc_d = ESC_IDLE;
      endcase
    end

    if (!consumed) begin
      case (ch)
        CH_NUL: ;
        CH_LF: begin
          res[0] = make_res(CMD_DRAW, col_q, row_q, CH_SPACE, WHITE_ALL);
          col_d  = 8'd0;
          if (row_q >= LastRow) begin
            row_d  = LastRow;
            res[1] = ScrollRes;
            n_res  = 2'd2;
          end else begin
            row_d = row_q + 8'd1;
            n_res = 2'd1;
          end
        end
        CH_CR: col_d = 8'd0;
        CH_TAB: col_d = (col_q + 8'd7) & 8'hf8;
        CH_BS: begin
          if (col_q > limit_q) begin
            res[0] = make_res(CMD_DRAW, col_q, row_q, CH_SPACE, WHITE_ALL);
            col_d  = col_q - 8'd1;
            n_res  = 2'd1;
          end
        end
        default: begin
          if (col_q >= ColsW) begin
            // Pending wrap: move to the next row first
            col_d = 8'd1;
            if (row_q >= LastRow) begin
              row_d  = LastRow;
              res[0] = ScrollRes;
              res[1] = make_res(CMD_DRAW, 8'd0, LastRow, ch, color_q);
              n_res  = 2'd2;
            end else begin
              row_d  = row_q + 8'd1;
              res[0] = make_res(CMD_DRAW, 8'd0, row_q + 8'd1, ch, color_q);
              n_res  = 2'd1;
            end
          end else begin
            res[0] = make_res(CMD_DRAW, col_q, row_q, ch, color_q);
            col_d  = col_q + 8'd1;
            n_res  = 2'd1;
          end
        end
      endcase
    end

    // Mark the last beat of this character
    res[0].last_of_run = (n_res == 2'd1);
    res[1].last_of_run = 1'b1;
  end

  // Hold parser, caret, color, limit and the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= ESC_IDLE;
      digit_q  <= 4'd0;
      color_q  <= WHITE_ALL;
      col_q    <= 8'd0;
      row_q    <= 8'd0;
      limit_q  <= 8'd0;
      in_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fire) begin
        esc_q   <= esc_d;
        digit_q <= digit_d;
        color_q <= color_d;
        col_q   <= col_d;
        row_q   <= row_d;
      end
      if (char_i.valid && char_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_q <= char_i.char_code;
    end
  end

  tccw_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (fire ? n_res : 2'd0),
    .push_data_i (res),
    .free_o      (free),
    .cmd_o       (cmd_o)
  );

endmodule

[rtl/tccw_result_queue.sv]
module tccw_result_queue import tccw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  res_t [1:0]    push_data_i,
  output logic [1:0]    free_o,
  tccw_cmd_if.source    cmd_o
);

  logic [1:0] count_q, count_d;
  res_t [1:0] slot_q, slot_d;
  logic       pop;
  logic [1:0] kept;
  res_t       sh0;

  // Drain one beat per cycle from the head slot while the consumer is ready
  assign cmd_o.valid       = (count_q != 2'd0);
  assign pop               = cmd_o.valid && cmd_o.ready;
  assign cmd_o.command     = slot_q[0].command;
  assign cmd_o.cell_column = slot_q[0].cell_column;
  assign cmd_o.cell_row    = slot_q[0].cell_row;
  assign cmd_o.glyph       = slot_q[0].glyph;
  assign cmd_o.draw_color  = slot_q[0].draw_color;
  assign cmd_o.last_of_run = slot_q[0].last_of_run;

  // Room left for this cycle, counting the beat that leaves now
  assign free_o = 2'd2 - count_q + {1'b0, pop};

  // Shift down on pop, then append the new beats behind what is kept
  always_comb begin
    kept      = count_q - {1'b0, pop};
    sh0       = pop ? slot_q[1] : slot_q[0];
    slot_d[0] = (kept == 2'd0) ? push_data_i[0] : sh0;
    if (kept == 2'd0) begin
      slot_d[1] = push_data_i[1];
    end else if (kept == 2'd1) begin
      slot_d[1] = push_data_i[0];
    end else begin
      slot_d[1] = slot_q[1];
    end
    count_d = kept + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
